@@ rtl/mvtr_pkg.sv @@
// Shared types and constants of the minutia vote template ranker.
package mvtr_pkg;

    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 14;
    localparam int LIMIT_W    = 7;
    localparam int ID_W       = 8;
    localparam int SCORE_W    = 16;
    localparam int THR_W      = 16;
    localparam int TIU_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_VOTE        = 2'd0,
        KIND_END_MINUTIA = 2'd1,
        KIND_FINISH      = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_MINUTIA_THR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_THR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATES_IN_USE = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic vote_load;
        logic vote_wr;
        logic fold_start;
        logic fold_rd;
        logic fold_acc;
        logic tot_wr;
        logic rank_start;
        logic rank_rd;
        logic rank_ins;
        logic emit_load;
        logic emit_shift;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic minutia_last;
        logic template_last;
        logic emit_last;
    } status_t;

endpackage

@@ rtl/mvtr_ctrl.sv @@
// Controller state machine of the minutia vote template ranker.
module mvtr_ctrl
    import mvtr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [KIND_W-1:0] s_kind,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  status_t           status,
    output cmd_t              cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b00000000001,
        ST_IDLE      = 11'b00000000010,
        ST_VOTE_RD   = 11'b00000000100,
        ST_VOTE_WR   = 11'b00000001000,
        ST_FOLD_RD   = 11'b00000010000,
        ST_FOLD_ACC  = 11'b00000100000,
        ST_TOT_RD    = 11'b00001000000,
        ST_TOT_WR    = 11'b00010000000,
        ST_RANK_RD   = 11'b00100000000,
        ST_RANK_INS  = 11'b01000000000,
        ST_EMIT_LOAD = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   emit_reg, emit_next;

    always_comb begin
        state_next = state_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (emit_reg) begin
                    if (m_ready) begin
                        if (status.emit_last) begin
                            emit_next = 1'b0;
                        end else begin
                            cmd.emit_shift = 1'b1;
                        end
                    end
                end else if (s_valid) begin
                    case (kind_t'(s_kind))
                        KIND_VOTE: begin
                            cmd.vote_load = 1'b1;
                            state_next    = ST_VOTE_RD;
                        end
                        KIND_END_MINUTIA: begin
                            cmd.fold_start = 1'b1;
                            state_next     = ST_FOLD_RD;
                        end
                        KIND_FINISH: begin
                            cmd.rank_start = 1'b1;
                            state_next     = ST_RANK_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_VOTE_RD: begin
                state_next = ST_VOTE_WR;
            end
            ST_VOTE_WR: begin
                cmd.vote_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_FOLD_RD: begin
                cmd.fold_rd = 1'b1;
                state_next  = ST_FOLD_ACC;
            end
            ST_FOLD_ACC: begin
                cmd.fold_acc = 1'b1;
                state_next   = status.minutia_last ? ST_TOT_RD : ST_FOLD_RD;
            end
            ST_TOT_RD: begin
                state_next = ST_TOT_WR;
            end
            ST_TOT_WR: begin
                cmd.tot_wr = 1'b1;
                state_next = status.template_last ? ST_IDLE : ST_FOLD_RD;
            end
            ST_RANK_RD: begin
                cmd.rank_rd = 1'b1;
                state_next  = ST_RANK_INS;
            end
            ST_RANK_INS: begin
                cmd.rank_ins = 1'b1;
                state_next   = status.template_last ? ST_EMIT_LOAD : ST_RANK_RD;
            end
            ST_EMIT_LOAD: begin
                cmd.emit_load = 1'b1;
                emit_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !emit_reg;
    assign m_valid = emit_reg;

    // The input side is closed while a result list drains.
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while results pending");

    // Results start only after the ranking walk has finished.
    a_emit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_EMIT_LOAD))
        else $error("result list started without ranking");

    // Every accumulate step follows the read it consumes.
    a_fold_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fold_acc |-> $past(cmd.fold_rd)) else $error("fold data used without read");

endmodule

@@ rtl/mvtr_datapath.sv @@
// Datapath of the minutia vote template ranker: memories, counters and rank list.
module mvtr_datapath
    import mvtr_pkg::*;
#(
    parameter int MAX_TEMPLATES         = 256,
    parameter int MINUTIAE_PER_TEMPLATE = 64,
    parameter int MAX_MATCHES           = 64,
    parameter int COUNT_WIDTH           = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [INDEX_W-1:0]    s_minutia_index,
    input  logic [LIMIT_W-1:0]    s_result_limit,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [ID_W-1:0]       m_template_id,
    output logic [SCORE_W-1:0]    m_template_score,
    output logic                  m_none_found,
    output logic                  m_last
);

    localparam int VOTE_SLOTS = MAX_TEMPLATES * MINUTIAE_PER_TEMPLATE;
    localparam int AW   = (VOTE_SLOTS > 1) ? $clog2(VOTE_SLOTS) : 1;
    localparam int TW   = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
    localparam int MW   = (MINUTIAE_PER_TEMPLATE > 1) ? $clog2(MINUTIAE_PER_TEMPLATE) : 1;
    localparam int HW   = $clog2(MINUTIAE_PER_TEMPLATE + 1);
    localparam int LVW0 = $clog2(MAX_TEMPLATES + 1);
    localparam int LVW  = (LVW0 > TIU_W) ? LVW0 : TIU_W;
    localparam int CMW0 = LVW + $clog2(MINUTIAE_PER_TEMPLATE + 1);
    localparam int CMW  = (CMW0 > INDEX_W) ? CMW0 : INDEX_W;
    localparam int SW   = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam int MMW  = $clog2(MAX_MATCHES + 1);

    logic [THR_W-1:0] mthr_reg, tthr_reg;
    logic [TIU_W-1:0] tiu_reg;

    logic [COUNT_WIDTH-1:0] votes_mem [VOTE_SLOTS];
    logic [COUNT_WIDTH-1:0] totals_mem [MAX_TEMPLATES];
    logic [COUNT_WIDTH-1:0] vm_rdata_reg, tm_rdata_reg;

    logic [AW-1:0] k_reg, k_next;
    logic [MW-1:0] m_reg, m_next;
    logic [TW-1:0] t_reg, t_next;
    logic [HW-1:0] hits_reg, hits_next;
    logic [AW-1:0] vaddr_reg;
    logic          vrange_reg;
    logic [LIMIT_W-1:0] cap_reg;
    logic [LIMIT_W-1:0] left_reg, left_next;
    logic [MMW-1:0]     cnt_reg, cnt_next;

    logic [TW-1:0]          lid_reg    [MAX_MATCHES];
    logic [TW-1:0]          lid_next   [MAX_MATCHES];
    logic [COUNT_WIDTH-1:0] lscore_reg [MAX_MATCHES];
    logic [COUNT_WIDTH-1:0] lscore_next[MAX_MATCHES];
    logic [MAX_MATCHES-1:0] lvalid_reg, lvalid_next, ge;

    logic [LVW-1:0]         live;
    logic                   t_live, k_in_tpl, rank_hit, vote_hit, fold_hit;
    logic [AW-1:0]          vm_addr;
    logic                   vm_we;
    logic [COUNT_WIDTH-1:0] vm_wdata;
    logic [TW-1:0]          tm_addr;
    logic                   tm_we;
    logic [COUNT_WIDTH-1:0] tm_wdata;
    logic [COUNT_WIDTH:0]   tot_sum;
    logic [LIMIT_W-1:0]     cap_in, cnt_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mthr_reg <= THR_W'(1);
            tthr_reg <= THR_W'(1);
            tiu_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MINUTIA_THR:      mthr_reg <= cfg_wr_data[THR_W-1:0];
                REG_TEMPLATE_THR:     tthr_reg <= cfg_wr_data[THR_W-1:0];
                REG_TEMPLATES_IN_USE: tiu_reg  <= cfg_wr_data[TIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign live = (LVW'(tiu_reg) > LVW'(MAX_TEMPLATES)) ? LVW'(MAX_TEMPLATES) : LVW'(tiu_reg);
    assign t_live   = LVW'(t_reg) < live;
    assign k_in_tpl = {1'b0, k_reg} < (AW + 1)'(MAX_TEMPLATES);
    assign vote_hit = vrange_reg && (vm_rdata_reg != '1);
    assign fold_hit = t_live && (SW'(vm_rdata_reg) >= SW'(mthr_reg));
    assign rank_hit = t_live && (SW'(tm_rdata_reg) >= SW'(tthr_reg));
    assign tot_sum  = (COUNT_WIDTH + 1)'(tm_rdata_reg) + (COUNT_WIDTH + 1)'(hits_reg);

    always_comb begin
        vm_addr  = k_reg;
        vm_we    = 1'b0;
        vm_wdata = '0;
        if (cmd.clear_step || cmd.fold_rd) begin
            vm_we = 1'b1;
        end else if (cmd.vote_wr) begin
            vm_addr  = vaddr_reg;
            vm_we    = vote_hit;
            vm_wdata = vm_rdata_reg + COUNT_WIDTH'(1);
        end else if (!cmd.fold_acc) begin
            vm_addr = vaddr_reg;
        end
    end

    always_comb begin
        tm_addr  = t_reg;
        tm_we    = 1'b0;
        tm_wdata = '0;
        if (cmd.clear_step) begin
            tm_addr = TW'(k_reg);
            tm_we   = k_in_tpl;
        end else if (cmd.rank_rd) begin
            tm_we = 1'b1;
        end else if (cmd.tot_wr) begin
            tm_we    = 1'b1;
            tm_wdata = tot_sum[COUNT_WIDTH] ? '1 : tot_sum[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (vm_we) begin
            votes_mem[vm_addr] <= vm_wdata;
        end
        vm_rdata_reg <= votes_mem[vm_addr];
    end

    always_ff @(posedge aclk) begin
        if (tm_we) begin
            totals_mem[tm_addr] <= tm_wdata;
        end
        tm_rdata_reg <= totals_mem[tm_addr];
    end

    always_comb begin
        k_next    = k_reg;
        m_next    = m_reg;
        t_next    = t_reg;
        hits_next = hits_reg;
        if (cmd.clear_step) begin
            k_next = status.clear_last ? '0 : k_reg + AW'(1);
        end
        if (cmd.fold_start || cmd.rank_start) begin
            k_next    = '0;
            m_next    = '0;
            t_next    = '0;
            hits_next = '0;
        end
        if (cmd.fold_acc) begin
            k_next = k_reg + AW'(1);
            m_next = status.minutia_last ? '0 : m_reg + MW'(1);
            if (fold_hit) begin
                hits_next = hits_reg + HW'(1);
            end
        end
        if (cmd.tot_wr) begin
            hits_next = '0;
            t_next    = t_reg + TW'(1);
        end
        if (cmd.rank_ins) begin
            t_next = t_reg + TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
        m_reg    <= m_next;
        t_reg    <= t_next;
        hits_reg <= hits_next;
        if (cmd.vote_load) begin
            vaddr_reg  <= AW'(s_minutia_index);
            vrange_reg <= CMW'(s_minutia_index) <
                          CMW'(live) * CMW'(MINUTIAE_PER_TEMPLATE);
        end
        if (cmd.rank_start) begin
            cap_reg <= cap_in;
        end
    end

    assign cap_in  = (s_result_limit > LIMIT_W'(MAX_MATCHES)) ? LIMIT_W'(MAX_MATCHES)
                                                               : s_result_limit;
    assign cnt_ext = LIMIT_W'(cnt_reg);

    always_comb begin
        for (int j = 0; j < MAX_MATCHES; j++) begin
            ge[j] = lvalid_reg[j] && (SW'(lscore_reg[j]) >= SW'(tm_rdata_reg));
        end
    end

    always_comb begin
        lid_next    = lid_reg;
        lscore_next = lscore_reg;
        lvalid_next = lvalid_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        if (cmd.rank_start) begin
            lvalid_next = '0;
            cnt_next    = '0;
        end else if (cmd.rank_ins && rank_hit) begin
            if (cnt_reg != MMW'(MAX_MATCHES)) begin
                cnt_next = cnt_reg + MMW'(1);
            end
            if (!ge[0]) begin
                lid_next[0]    = t_reg;
                lscore_next[0] = tm_rdata_reg;
                lvalid_next[0] = 1'b1;
            end
            for (int j = 1; j < MAX_MATCHES; j++) begin
                if (!ge[j]) begin
                    if (ge[j-1]) begin
                        lid_next[j]    = t_reg;
                        lscore_next[j] = tm_rdata_reg;
                        lvalid_next[j] = 1'b1;
                    end else begin
                        lid_next[j]    = lid_reg[j-1];
                        lscore_next[j] = lscore_reg[j-1];
                        lvalid_next[j] = lvalid_reg[j-1];
                    end
                end
            end
        end else if (cmd.emit_shift) begin
            for (int j = 0; j < MAX_MATCHES - 1; j++) begin
                lid_next[j]    = lid_reg[j+1];
                lscore_next[j] = lscore_reg[j+1];
                lvalid_next[j] = lvalid_reg[j+1];
            end
            lvalid_next[MAX_MATCHES-1] = 1'b0;
            left_next = left_reg - LIMIT_W'(1);
        end
        if (cmd.emit_load) begin
            left_next = (cnt_ext < cap_reg) ? cnt_ext : cap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvalid_reg <= '0;
            cnt_reg    <= '0;
            left_reg   <= '0;
        end else begin
            lvalid_reg <= lvalid_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
        end
        lid_reg    <= lid_next;
        lscore_reg <= lscore_next;
    end

    assign status.clear_last    = k_reg == AW'(VOTE_SLOTS - 1);
    assign status.minutia_last  = m_reg == MW'(MINUTIAE_PER_TEMPLATE - 1);
    assign status.template_last = t_reg == TW'(MAX_TEMPLATES - 1);
    assign status.emit_last     = left_reg <= LIMIT_W'(1);

    assign m_none_found     = left_reg == '0;
    assign m_last           = status.emit_last;
    assign m_template_id    = m_none_found ? '0 : ID_W'(lid_reg[0]);
    assign m_template_score = m_none_found ? '0 : SCORE_W'(lscore_reg[0]);

    // A shift only happens while more than one result remains.
    a_shift_left: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_shift |-> left_reg > LIMIT_W'(1)) else $error("rank list overrun");

endmodule

@@ rtl/minutia_vote_template_ranker_top.sv @@
// A vote item is a memory read, then a write of the counter.
// An end-of-minutia item reads and clears every vote counter and adds each
// template's hits to its total. A finish item ranks the templates, then sends
// one result beat per cycle while m_ready is high. The vote and score memories
// have one port each. After reset a clearing pass holds s_ready low.
module minutia_vote_template_ranker_top
    import mvtr_pkg::*;
#(
    parameter int MAX_TEMPLATES         = 256,
    parameter int MINUTIAE_PER_TEMPLATE = 64,
    parameter int MAX_MATCHES           = 64,
    parameter int COUNT_WIDTH           = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [INDEX_W-1:0]    s_minutia_index,
    input  logic [LIMIT_W-1:0]    s_result_limit,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_W-1:0]       m_template_id,
    output logic [SCORE_W-1:0]    m_template_score,
    output logic                  m_none_found,
    output logic                  m_last
);

    cmd_t    cmd;
    status_t status;

    mvtr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mvtr_datapath #(
        .MAX_TEMPLATES         (MAX_TEMPLATES),
        .MINUTIAE_PER_TEMPLATE (MINUTIAE_PER_TEMPLATE),
        .MAX_MATCHES           (MAX_MATCHES),
        .COUNT_WIDTH           (COUNT_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_minutia_index  (s_minutia_index),
        .s_result_limit   (s_result_limit),
        .cmd              (cmd),
        .status           (status),
        .m_template_id    (m_template_id),
        .m_template_score (m_template_score),
        .m_none_found     (m_none_found),
        .m_last           (m_last)
    );

endmodule
